[rtl/core/ttcs_pkg.sv]
`timescale 1ns / 1ps
package ttcs_pkg;

    localparam int WB_SLOTS_DEF   = 512;
    localparam int LOCAL_ENT_DEF  = 32;
    localparam int GLOBAL_SL_DEF  = 64;

    localparam logic [7:0]  NODE_ID_RST   = 8'd1;
    localparam logic [31:0] SLOT_DUR_RST  = 32'd10000;
    localparam logic [6:0]  SCHED_LEN_RST = 7'd6;

    localparam logic [63:0] REF_OFFSET = 64'd1280;
    localparam logic [63:0] TIME_MASK  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SOS_BIT    = 64'h8000_0000_0000_0000;
    localparam int          SLOT_W     = 14;
    localparam int          ROM_USED   = 6;

    localparam logic [1:0] CFG_NODE_ID   = 2'd0;
    localparam logic [1:0] CFG_SLOT_DUR  = 2'd1;
    localparam logic [1:0] CFG_SCHED_LEN = 2'd2;

    localparam logic [2:0] KIND_BUILD = 3'd0;
    localparam logic [2:0] KIND_FRAME = 3'd1;
    localparam logic [2:0] KIND_TIMER = 3'd2;
    localparam logic [2:0] KIND_START = 3'd3;
    localparam logic [2:0] KIND_HOST  = 3'd4;

    localparam logic [1:0] RK_RELOAD = 2'd0;
    localparam logic [1:0] RK_TX     = 2'd1;
    localparam logic [1:0] RK_ERR    = 2'd2;
    localparam logic [1:0] RK_BUILD  = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_BUILD = 3'd1,
        OP_REF   = 3'd2,
        OP_DATA  = 3'd3,
        OP_ERR   = 3'd4,
        OP_TIMER = 3'd5,
        OP_START = 3'd6,
        OP_HOST  = 3'd7
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [13:0] addr;
        logic [63:0] data;
    } req_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [31:0] slot_dur;
        logic [6:0]  sched_len;
    } cfg_t;

    function automatic logic [7:0] rom_node(input logic [8:0] i);
        logic [7:0] r;
        unique case (i)
            9'd0:    r = 8'd1;
            9'd1:    r = 8'd8;
            9'd2:    r = 8'd9;
            9'd3:    r = 8'd10;
            9'd4:    r = 8'd1;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] rom_slot(input logic [8:0] i);
        logic [13:0] r;
        unique case (i)
            9'd1:    r = 14'd3;
            9'd2:    r = 14'd4;
            9'd3:    r = 14'd5;
            9'd4:    r = 14'd2;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/ttcs_front.sv]
`timescale 1ns / 1ps
module ttcs_front #(
    parameter int WB_SLOTS = ttcs_pkg::WB_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [103:0]      s_tdata,
    input  logic [2:0]        s_tuser,
    input  ttcs_pkg::back_ctl_t ctl,
    output ttcs_pkg::req_t    q_head,
    output logic              q_valid
);
    import ttcs_pkg::*;

    req_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic [28:0] fid;
    logic [13:0] sid;
    logic [8:0]  hslot;
    req_t        cls;
    logic        accept, push;

    assign fid   = s_tdata[28:0];
    assign sid   = fid[13:0];
    assign hslot = s_tdata[101:93];

    always_comb begin
        cls.op   = OP_NONE;
        cls.addr = sid;
        cls.data = s_tdata[92:29];
        unique case (s_tuser)
            KIND_BUILD: cls.op = OP_BUILD;
            KIND_FRAME: begin
                if (sid == 14'd0) cls.op = OP_REF;
                else if (sid < 14'(WB_SLOTS - 1)) cls.op = OP_DATA;
                else cls.op = OP_ERR;
            end
            KIND_TIMER: cls.op = OP_TIMER;
            KIND_START: cls.op = OP_START;
            KIND_HOST: begin
                cls.addr = {5'd0, hslot};
                if ({4'd0, hslot} < 13'(WB_SLOTS)) cls.op = OP_HOST;
            end
            default: cls.op = OP_NONE;
        endcase
    end

    assign s_tready = (count_reg != 2'd2) && !ctl.clearing;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (cls.op != OP_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ ctl.pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, ctl.pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= cls;
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> q_valid) else $error("pop from empty queue");

endmodule

[rtl/core/ttcs_back.sv]
`timescale 1ns / 1ps
module ttcs_back #(
    parameter int WB_SLOTS  = ttcs_pkg::WB_SLOTS_DEF,
    parameter int LOCAL_ENT = ttcs_pkg::LOCAL_ENT_DEF,
    parameter int GLOBAL_SL = ttcs_pkg::GLOBAL_SL_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ttcs_pkg::cfg_t     cfg,
    input  ttcs_pkg::req_t     q_head,
    input  logic               q_valid,
    output ttcs_pkg::back_ctl_t ctl,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,
    output logic [1:0]         m_tuser
);
    import ttcs_pkg::*;

    localparam int WBW = $clog2(WB_SLOTS);
    localparam int LAW = (LOCAL_ENT > 1) ? $clog2(LOCAL_ENT) : 1;
    localparam int LLW = $clog2(LOCAL_ENT + 1);
    localparam int GW  = $clog2(GLOBAL_SL);
    localparam int EW  = GW + SLOT_W;

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_BUILD = 8'b0000_0100,
        S_T0    = 8'b0000_1000,
        S_T1    = 8'b0001_0000,
        S_T2    = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [63:0] wb_mem [WB_SLOTS];
    logic [EW-1:0] ls_mem [LOCAL_ENT];
    logic [63:0]   wb_rdata_reg;
    logic [EW-1:0] ls_rdata_reg;

    logic          wb_we;
    logic [WBW-1:0] wb_waddr, wb_raddr;
    logic [63:0]   wb_wdata;
    logic          ls_we;
    logic [LAW-1:0] ls_waddr, ls_raddr;
    logic [EW-1:0] ls_wdata;

    logic [WBW-1:0] clr_reg;
    logic [LLW-1:0] len_reg;
    logic [LAW-1:0] idx_reg;
    logic           active_reg;
    logic [GW-1:0]  first_reg;
    logic [8:0]     bi_reg;
    logic [GW-1:0]  cur_gidx_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic           slot_ok_reg;
    logic [31:0]    diff_reg, prod_reg;
    logic           sub_off_reg;
    logic [1:0]     rk_reg;
    logic [28:0]    rid_reg;
    logic [63:0]    rdata_reg;
    logic           rtv_reg;

    logic           m_tvalid_reg;
    logic [127:0]   m_tdata_reg;
    logic [1:0]     m_tuser_reg;

    logic [63:0]    ref_sum;
    logic [8:0]     nlim;
    logic [LAW-1:0] cur;
    logic           build_go, match, has_next, out_free, ref_go;
    logic [GW-1:0]  e_gidx;
    logic [SLOT_W-1:0] e_slot;
    logic [31:0]    prod_full;
    logic [31:0]    tl;

    assign ref_sum  = q_head.data + REF_OFFSET;
    assign ref_go   = (q_head.op == OP_REF) && ref_sum[63] && (len_reg != '0);
    assign nlim     = ({2'd0, cfg.sched_len} > 9'(GLOBAL_SL)) ? 9'(GLOBAL_SL)
                                                               : {2'd0, cfg.sched_len};
    assign cur      = (LLW'(idx_reg) >= len_reg) ? '0 : idx_reg;
    assign build_go = (bi_reg < nlim) && (len_reg < LLW'(LOCAL_ENT));
    assign match    = (rom_node(bi_reg) == cfg.node_id);
    assign has_next = (LLW'(idx_reg) + LLW'(1)) < len_reg;
    assign e_gidx   = ls_rdata_reg[EW-1:SLOT_W];
    assign e_slot   = ls_rdata_reg[SLOT_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign prod_full = diff_reg * cfg.slot_dur;
    assign tl       = prod_reg - (sub_off_reg ? REF_OFFSET[31:0] : 32'd0);

    assign ctl.pop      = (state_reg == S_IDLE) && q_valid;
    assign ctl.clearing = (state_reg == S_CLR);

    always_comb begin
        wb_we    = 1'b0;
        wb_waddr = q_head.addr[WBW-1:0];
        wb_wdata = q_head.data;
        if (state_reg == S_CLR) begin
            wb_we    = 1'b1;
            wb_waddr = clr_reg;
            wb_wdata = '0;
        end else if (ctl.pop) begin
            unique case (q_head.op)
                OP_REF: begin
                    wb_we    = 1'b1;
                    wb_waddr = '0;
                    wb_wdata = ref_sum & TIME_MASK;
                end
                OP_DATA, OP_HOST: wb_we = 1'b1;
                default: wb_we = 1'b0;
            endcase
        end
    end

    assign wb_raddr = e_slot[WBW-1:0];
    assign ls_we    = (state_reg == S_BUILD) && build_go && match;
    assign ls_waddr = len_reg[LAW-1:0];
    assign ls_wdata = {bi_reg[GW-1:0], rom_slot(bi_reg)};
    assign ls_raddr = (state_reg == S_T0) ? cur : (idx_reg + LAW'(1));

    always_ff @(posedge aclk) begin
        if (wb_we) wb_mem[wb_waddr] <= wb_wdata;
        wb_rdata_reg <= wb_mem[wb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
        ls_rdata_reg <= ls_mem[ls_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_FIN) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + WBW'(1);
                    if (clr_reg == WBW'(WB_SLOTS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_valid) begin
                        rk_reg      <= (q_head.op == OP_ERR) ? RK_ERR : RK_RELOAD;
                        rid_reg     <= '0;
                        rdata_reg   <= '0;
                        rtv_reg     <= ref_go;
                        sub_off_reg <= ref_go;
                        unique case (q_head.op)
                            OP_BUILD: begin
                                len_reg   <= '0;
                                idx_reg   <= '0;
                                bi_reg    <= '0;
                                state_reg <= S_BUILD;
                            end
                            OP_REF: begin
                                if (ref_sum[63]) begin
                                    active_reg <= 1'b1;
                                    idx_reg    <= '0;
                                    if (len_reg != '0) begin
                                        diff_reg  <= 32'(first_reg);
                                        state_reg <= S_MUL;
                                    end
                                end
                            end
                            OP_ERR: begin
                                state_reg <= S_FIN;
                            end
                            OP_TIMER: begin
                                if (active_reg && len_reg != '0) state_reg <= S_T0;
                            end
                            OP_START: begin
                                active_reg <= 1'b1;
                                idx_reg    <= '0;
                                if (len_reg != '0) state_reg <= S_T0;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_BUILD: begin
                    if (build_go) begin
                        if (match) begin
                            if (len_reg == '0) first_reg <= bi_reg[GW-1:0];
                            len_reg <= len_reg + LLW'(1);
                        end
                        bi_reg <= bi_reg + 9'd1;
                    end else begin
                        rk_reg    <= RK_BUILD;
                        state_reg <= S_FIN;
                    end
                end
                S_T0: begin
                    idx_reg   <= cur;
                    state_reg <= S_T1;
                end
                S_T1: begin
                    cur_gidx_reg <= e_gidx;
                    cur_slot_reg <= e_slot;
                    slot_ok_reg  <= ({2'd0, e_slot} < 16'(WB_SLOTS));
                    state_reg    <= S_T2;
                end
                S_T2: begin
                    if (has_next) begin
                        diff_reg <= 32'(e_gidx) - 32'(cur_gidx_reg);
                        idx_reg  <= idx_reg + LAW'(1);
                    end else begin
                        diff_reg <= 32'(cfg.sched_len) - 32'(cur_gidx_reg)
                                    + 32'(first_reg);
                        idx_reg  <= '0;
                    end
                    rk_reg    <= RK_TX;
                    rid_reg   <= 29'({cur_gidx_reg, cur_slot_reg});
                    rdata_reg <= (slot_ok_reg ? wb_rdata_reg : 64'd0)
                                 | ((cur_gidx_reg == '0) ? SOS_BIT : 64'd0);
                    rtv_reg   <= 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= prod_full;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_tuser_reg <= rk_reg;
            m_tdata_reg <= {2'd0, (rtv_reg ? tl : 32'd0), rtv_reg, rdata_reg, rid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LLW'(LOCAL_ENT)) else $error("local length overflow");
    a_no_pop_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !ctl.pop) else $error("pop during clear");
    a_fin_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !out_free) |=> (state_reg == S_FIN))
        else $error("result dropped");

endmodule

[rtl/core/time_triggered_can_scheduler_unit.sv]
`timescale 1ns / 1ps
// Result path: an invalid frame goes through S_FIN; a timer reload through S_MUL and S_FIN;
// a transmit through S_T0, S_T1, S_T2, S_MUL and S_FIN; a build walks the global slots in S_BUILD.
// The back end takes one request at a time; stores (data, host) give no result, and output
// stalls hold a result in S_FIN; a 2-entry queue sits in front.
// Reset: synchronous active-low; a whiteboard clearing pass over all WB_SLOTS entries follows,
// during which s_tready is low. Config writes are taken at all times.
module time_triggered_can_scheduler_unit #(
    parameter int WB_SLOTS  = ttcs_pkg::WB_SLOTS_DEF,
    parameter int LOCAL_ENT = ttcs_pkg::LOCAL_ENT_DEF,
    parameter int GLOBAL_SL = ttcs_pkg::GLOBAL_SL_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // frame_id_in, frame_data_in, host_slot
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // frame_id_out, frame_data_out, timer_valid, timer_load
    output logic [1:0]   m_tuser    // result_kind
);
    import ttcs_pkg::*;

    cfg_t      cfg_reg;
    back_ctl_t ctl;
    req_t      q_head;
    logic      q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_id   <= NODE_ID_RST;
            cfg_reg.slot_dur  <= SLOT_DUR_RST;
            cfg_reg.sched_len <= SCHED_LEN_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_NODE_ID:   cfg_reg.node_id   <= cfg_wdata[7:0];
                CFG_SLOT_DUR:  cfg_reg.slot_dur  <= cfg_wdata;
                CFG_SCHED_LEN: cfg_reg.sched_len <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    ttcs_front #(.WB_SLOTS(WB_SLOTS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .ctl(ctl), .q_head(q_head), .q_valid(q_valid)
    );

    ttcs_back #(.WB_SLOTS(WB_SLOTS), .LOCAL_ENT(LOCAL_ENT), .GLOBAL_SL(GLOBAL_SL)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_head(q_head), .q_valid(q_valid), .ctl(ctl),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

[verif/time_triggered_can_scheduler_checker.sv]
`timescale 1ns / 1ps
module time_triggered_can_scheduler_checker
    import ttcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,   // frame_id_in, frame_data_in, host_slot
    input  logic [2:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,   // frame_id_out, frame_data_out, timer_valid, timer_load
    input  logic [1:0]   m_tuser,   // result_kind
    output int           fail_cnt,
    output int           pending,
    output int           checked
);

    typedef struct {
        logic [1:0]  kind;
        logic [28:0] fid;
        logic [63:0] fdata;
        logic        tvalid;
        logic [31:0] tload;
    } sched_result_t;

    sched_result_t expected_results[$];

    logic [7:0]  node_id;
    logic [31:0] slot_dur;
    logic [6:0]  round_len;

    logic [63:0] board [WB_SLOTS_DEF];
    logic [5:0]  plan_gidx [LOCAL_ENT_DEF];
    logic [13:0] plan_slot [LOCAL_ENT_DEF];
    int unsigned plan_len;
    int unsigned plan_pos;
    bit          active;

    // global slot table: (node, whiteboard slot), empty from the sixth entry on
    localparam logic [7:0]  TBL_NODE [6] = '{8'd1, 8'd8, 8'd9, 8'd10, 8'd1, 8'd0};
    localparam logic [13:0] TBL_SLOT [6] = '{14'd0, 14'd3, 14'd4, 14'd5, 14'd2, 14'd0};

    initial begin
        fail_cnt = 0;
        pending  = 0;
        checked  = 0;
    end

    task automatic push_result(input logic [1:0] k, input logic [28:0] id,
                               input logic [63:0] d, input logic tv, input logic [31:0] tl);
        sched_result_t r;
        r.kind = k; r.fid = id; r.fdata = d; r.tvalid = tv; r.tload = tl;
        expected_results.push_back(r);
    endtask

    task automatic send_next_frame();
        logic [5:0]  g;
        logic [5:0]  nxt;
        logic [13:0] sl;
        logic [63:0] d;
        logic [31:0] t;
        if (!active || plan_len == 0) return;
        if (plan_pos >= plan_len) plan_pos = 0;
        g  = plan_gidx[plan_pos];
        sl = plan_slot[plan_pos];
        d  = (sl < WB_SLOTS_DEF) ? board[sl[8:0]] : 64'd0;
        if (g == 0) d |= SOS_BIT;
        if (plan_pos + 1 < plan_len) begin
            plan_pos++;
            nxt = plan_gidx[plan_pos];
            t = (32'(nxt) - 32'(g)) * slot_dur;
        end else begin
            plan_pos = 0;
            nxt = plan_gidx[0];
            t = (32'(round_len) - 32'(g)) * slot_dur + 32'(nxt) * slot_dur;
        end
        push_result(RK_TX, (29'(g) << 14) | 29'(sl), d, 1'b1, t);
    endtask

    task automatic predict_request(input logic [2:0] k, input logic [28:0] fid,
                                   input logic [63:0] fdata, input logic [8:0] hslot);
        int unsigned n;
        logic [13:0] sid;
        logic [63:0] sum;
        logic [7:0]  nd;
        logic [13:0] ns;
        case (k)
            KIND_BUILD: begin
                n = (round_len > GLOBAL_SL_DEF) ? GLOBAL_SL_DEF : round_len;
                plan_len = 0;
                plan_pos = 0;
                for (int i = 0; i < n && plan_len < LOCAL_ENT_DEF; i++) begin
                    nd = (i < 6) ? TBL_NODE[i] : 8'd0;
                    ns = (i < 6) ? TBL_SLOT[i] : 14'd0;
                    if (nd == node_id) begin
                        plan_gidx[plan_len] = 6'(i);
                        plan_slot[plan_len] = ns;
                        plan_len++;
                    end
                end
                push_result(RK_BUILD, '0, '0, 1'b0, '0);
            end
            KIND_FRAME: begin
                sid = fid[13:0];
                if (sid == 0) begin
                    sum = fdata + REF_OFFSET;
                    board[0] = sum & TIME_MASK;
                    if (sum[63]) begin
                        active   = 1'b1;
                        plan_pos = 0;
                        if (plan_len != 0)
                            push_result(RK_RELOAD, '0, '0, 1'b1,
                                        32'(plan_gidx[0]) * slot_dur - 32'(REF_OFFSET));
                    end
                end else if (sid < WB_SLOTS_DEF - 1) begin
                    board[sid[8:0]] = fdata;
                end else begin
                    push_result(RK_ERR, '0, '0, 1'b0, '0);
                end
            end
            KIND_TIMER: send_next_frame();
            KIND_START: begin
                plan_pos = 0;
                active   = 1'b1;
                send_next_frame();
            end
            KIND_HOST: board[hslot] = fdata;
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            node_id   = NODE_ID_RST;
            slot_dur  = SLOT_DUR_RST;
            round_len = SCHED_LEN_RST;
            for (int i = 0; i < WB_SLOTS_DEF; i++) board[i] = '0;
            plan_len = 0;
            plan_pos = 0;
            active   = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_NODE_ID:   node_id   = cfg_wdata[7:0];
                    CFG_SLOT_DUR:  slot_dur  = cfg_wdata;
                    CFG_SCHED_LEN: round_len = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d", m_tuser);
                    fail_cnt++;
                end else begin
                    sched_result_t e;
                    e = expected_results.pop_front();
                    checked++;
                    if (m_tuser !== e.kind) begin
                        $error("result_kind: expected %0d, got %0d", e.kind, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[28:0] !== e.fid) begin
                        $error("frame_id_out: expected %h, got %h", e.fid, m_tdata[28:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[92:29] !== e.fdata) begin
                        $error("frame_data_out: expected %h, got %h", e.fdata, m_tdata[92:29]);
                        fail_cnt++;
                    end
                    if (m_tdata[93] !== e.tvalid) begin
                        $error("timer_valid: expected %0d, got %0d", e.tvalid, m_tdata[93]);
                        fail_cnt++;
                    end
                    if (m_tdata[125:94] !== e.tload) begin
                        $error("timer_load: expected %h, got %h", e.tload, m_tdata[125:94]);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[28:0], s_tdata[92:29], s_tdata[101:93]);
        end
        pending = expected_results.size();
    end

endmodule

[verif/tb_time_triggered_can_scheduler_unit.sv]
`timescale 1ns / 1ps
module tb_time_triggered_can_scheduler_unit;
    import ttcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = 100;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    int  fail_cnt;
    int  pending;
    int  checked;
    int  sent;
    int  idle_cycles;
    int  stall_left;
    bit  src_gaps;
    bit  sink_stalls;
    logic s_fire;

    time_triggered_can_scheduler_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    time_triggered_can_scheduler_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_cnt(fail_cnt), .pending(pending), .checked(checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) s_fire <= aresetn && s_tvalid && s_tready;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure: mostly short stalls, a few long ones
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_stalls && $urandom_range(99) < 25)
                stall_left <= ($urandom_range(19) == 0) ? $urandom_range(40, 10)
                                                        : $urandom_range(3, 1);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!src_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_request(input logic [2:0] k, input logic [28:0] fid,
                                input logic [63:0] d, input logic [8:0] hslot);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {2'b00, hslot, d, fid};
        do @(negedge aclk); while (!s_fire);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] a, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(negedge aclk);
    endtask

    task automatic drain_and_configure(input logic [7:0] nid, input logic [31:0] dur,
                                       input logic [6:0] len);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(CFG_NODE_ID, {24'd0, nid});
        write_reg(CFG_SLOT_DUR, dur);
        write_reg(CFG_SCHED_LEN, {25'd0, len});
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int r;
        logic [28:0] fid;
        logic [63:0] d;
        r   = $urandom_range(99);
        fid = 29'($urandom());
        d   = {32'($urandom()), 32'($urandom())};
        if (r < 4) begin
            send_request(KIND_BUILD, fid, d, 9'($urandom()));
        end else if (r < 12) begin
            // start of schedule reference frame
            fid[13:0] = '0;
            d[63] = 1'b1;
            send_request(KIND_FRAME, fid, d, 9'($urandom()));
        end else if (r < 16) begin
            fid[13:0] = '0;
            send_request(KIND_FRAME, fid, d, 9'($urandom()));
        end else if (r < 30) begin
            fid[13:0] = 14'($urandom_range(WB_SLOTS_DEF - 2, 1));
            send_request(KIND_FRAME, fid, d, 9'($urandom()));
        end else if (r < 35) begin
            fid[13:0] = 14'($urandom_range(16383, WB_SLOTS_DEF - 1));
            send_request(KIND_FRAME, fid, d, 9'($urandom()));
        end else if (r < 70) begin
            send_request(KIND_TIMER, fid, d, 9'($urandom()));
        end else if (r < 76) begin
            send_request(KIND_START, fid, d, 9'($urandom()));
        end else if (r < 95) begin
            send_request(KIND_HOST, fid, d, 9'($urandom()));
        end else begin
            send_request(3'($urandom_range(7, 5)), fid, d, 9'($urandom()));
        end
    endtask

    initial begin
        logic [7:0]  nids [8] = '{8'd1, 8'd8, 8'd0, 8'd9, 8'd10, 8'd200, 8'd1, 8'd0};
        logic [6:0]  lens [8] = '{7'd6, 7'd64, 7'd127, 7'd1, 7'd1, 7'd64, 7'd5, 7'd64};
        logic [31:0] durs [8];
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
        sent        = 0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        durs = '{32'd10000, 32'd0, 32'hFFFF_FFFF, $urandom(), 32'd1,
                 $urandom(), $urandom(), $urandom()};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset configuration
        send_request(KIND_TIMER, '0, '0, '0);                      // inactive, no result
        send_request(KIND_START, '0, '0, '0);                      // empty plan
        send_request(KIND_BUILD, '1, '1, '1);
        send_request(KIND_FRAME, 29'd0, 64'h7FFF_FFFF_FFFF_FAFF, '0); // no start of schedule
        send_request(KIND_FRAME, 29'h1FFF_C000, 64'h7FFF_FFFF_FFFF_FB00, '0);
        send_request(KIND_FRAME, 29'd0, '1, '0);                   // sum wraps
        send_request(KIND_FRAME, 29'd2, '1, '0);
        send_request(KIND_FRAME, 29'd1, 64'h1234_5678_9ABC_DEF0, '0);
        send_request(KIND_FRAME, 29'd510, 64'hA5A5_5A5A_0F0F_F0F0, '0);
        send_request(KIND_FRAME, 29'd511, '0, '0);                 // invalid slot
        send_request(KIND_FRAME, 29'h1FFF_FFFF, '1, '1);           // invalid slot
        send_request(KIND_HOST, '0, '1, 9'd0);
        send_request(KIND_HOST, '1, 64'hDEAD_BEEF_0000_0001, 9'd511);
        send_request(KIND_HOST, '0, 64'h0BAD_F00D_CAFE_0002, 9'd2);
        send_request(KIND_START, '0, '0, '0);
        send_request(KIND_TIMER, '0, '0, '0);
        send_request(KIND_TIMER, '0, '0, '0);
        send_request(3'd5, '1, '1, '1);
        send_request(3'd6, '0, '0, '0);
        send_request(3'd7, '1, '0, '1);
        send_request(KIND_FRAME, 29'h4000, 64'h8000_0000_0000_0000, '0);
        send_request(KIND_TIMER, '0, '0, '0);

        for (int p = 0; p < 8; p++) begin
            drain_and_configure(nids[p], durs[p], lens[p]);
            src_gaps    = (p % 3) != 2;
            sink_stalls = (p % 4) != 1;
            send_request(KIND_BUILD, 29'($urandom()), '0, '0);
            for (int i = 0; i < PHASE_ITEMS; i++) random_request();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Sent %0d requests over 8 register settings; %0d results checked.",
                 sent, checked);
        $display("Covered build, reference, data, invalid, timer, start and host requests.");
        if (fail_cnt == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
